@@ hdl/ffa_pkg.sv @@
// shared constants and codes for the first-fit aligned allocator
package ffa_pkg;

  // default sizing
  localparam int FREE_SLOTS_DEF = 64;
  localparam int ADDR_BITS_DEF  = 32;

  // register reset values
  localparam logic [31:0] POOL_RESET  = 32'd16777216;
  localparam logic [4:0]  ALIGN_RESET = 5'd8;

  // configuration register indexes
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_POOL  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_ALIGN = 1'b1;

  // request actions
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_LOST  = 2'd2;

endpackage

@@ hdl/first_fit_aligned_allocator.sv @@
// first-fit aligned pool allocator over an ordered free list
//
//  channel  direction  handshake             payload
//  cfg      in         cfg_we                cfg_index, cfg_data
//  in       in         in_valid, in_stall    action, byte_count, block_offset
//  out      out        out_valid, out_stall  status, granted_offset, used_bytes, free_entries
//
// a free request has its result valid in the cycle after it is taken.
// an allocate request scans one entry per cycle until the first fit, then an update step shrinks
// the entry or, when it is used up, close-up steps move the later entries down, and a finish
// step answers; with no fit the result follows the scan of the last entry.
// after reset the init state writes the whole-pool entry before the first request is taken.
// a new request is taken only while the block is idle and no result is waiting.
module first_fit_aligned_allocator #(
  parameter int FREE_SLOTS = ffa_pkg::FREE_SLOTS_DEF,
  parameter int ADDR_BITS  = ffa_pkg::ADDR_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [ffa_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                  cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         action,
  input  logic [31:0]                  byte_count,
  input  logic [31:0]                  block_offset,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   status,
  output logic [31:0]                  granted_offset,
  output logic [31:0]                  used_bytes,
  output logic [6:0]                   free_entries
);

  localparam int IW = $clog2(FREE_SLOTS);
  localparam int CW = $clog2(FREE_SLOTS + 1);
  localparam int A  = ADDR_BITS;
  localparam int SW = ((ADDR_BITS > 32) ? ADDR_BITS : 32) + 1;
  localparam int EW = 2 * ADDR_BITS;

  typedef enum logic [5:0] {
    SM_INIT  = 6'b000001,
    SM_IDLE  = 6'b000010,
    SM_SCAN  = 6'b000100,
    SM_UPD   = 6'b001000,
    SM_SHIFT = 6'b010000,
    SM_FIN   = 6'b100000
  } state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [31:0]   used_total;
  logic [31:0]   pool_bytes;
  logic [4:0]    align_log2;
  logic [IW-1:0] scan_idx;
  logic [IW-1:0] shift_idx;
  logic [A-1:0]  cnt_r;
  logic [IW-1:0] hit_idx;
  logic [A-1:0]  hit_off;
  logic [A-1:0]  hit_size;
  logic [A-1:0]  hit_aligned;
  logic [A-1:0]  hit_pad;
  logic [A:0]    hit_pc;

  // free list memory, offset in the upper half, size in the lower half
  logic [EW-1:0] mem [FREE_SLOTS];
  logic [EW-1:0] rd_data;
  logic [IW-1:0] rd_addr;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [EW-1:0] mem_wd;

  logic          accept;
  logic [A-1:0]  in_cnt;
  logic [A-1:0]  rd_off;
  logic [A-1:0]  rd_size;
  logic [SW-1:0] am;
  logic [SW-1:0] sum;
  logic [SW-1:0] aligned_w;
  logic          in_range;
  logic [A-1:0]  pad_c;
  logic [A:0]    pc_c;
  logic          fit;
  logic          scan_last;
  logic          shift_last;
  logic [A:0]    rest_w;
  logic [A-1:0]  rest;
  logic [A-1:0]  new_off;
  logic          room;
  logic [32:0]   used_sum;
  logic [31:0]   used_add;
  logic [31:0]   used_sub;
  logic [6:0]    ent_now;
  logic [6:0]    ent_app;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != SM_IDLE) || out_valid;
  assign in_cnt   = A'(byte_count);

  // candidate entry check: round offset up, padding, fit test
  assign rd_off    = rd_data[EW-1:A];
  assign rd_size   = rd_data[A-1:0];
  assign am        = (SW'(1) << align_log2) - SW'(1);
  assign sum       = SW'(rd_off) + am;
  assign aligned_w = sum & ~am;
  assign in_range  = (aligned_w >> A) == '0;
  assign pad_c     = (~rd_off + A'(1)) & am[A-1:0];
  assign pc_c      = (A+1)'(pad_c) + (A+1)'(cnt_r);
  assign fit       = in_range && (pc_c <= (A+1)'(rd_size));
  assign scan_last = (CW'(scan_idx) + CW'(1)) == count;

  // shrink of the chosen entry
  assign rest_w  = (A+1)'(hit_size) - hit_pc;
  assign rest    = rest_w[A-1:0];
  assign new_off = hit_aligned + cnt_r;

  assign shift_last = (CW'(shift_idx) + CW'(2)) == count;
  assign room       = count < CW'(FREE_SLOTS);

  // used byte bookkeeping, saturating both ways
  assign used_sum = 33'(used_total) + 33'(cnt_r);
  assign used_add = used_sum[32] ? '1 : used_sum[31:0];
  assign used_sub = (33'(in_cnt) >= 33'(used_total)) ? '0 : (used_total - 32'(in_cnt));

  assign ent_now = 7'(count);
  assign ent_app = 7'(count + CW'(1));

  // memory write port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    if (cfg_we && cfg_index == ffa_pkg::REG_POOL) begin
      mem_we = 1'b1;
      mem_wd = {A'(0), A'(cfg_data)};
    end else begin
      unique case (state)
        SM_INIT: begin
          mem_we = 1'b1;
          mem_wd = {A'(0), A'(pool_bytes)};
        end
        SM_IDLE: begin
          if (accept && action == ffa_pkg::ACT_FREE && room) begin
            mem_we = 1'b1;
            mem_wa = count[IW-1:0];
            mem_wd = {A'(block_offset), in_cnt};
          end
        end
        SM_UPD: begin
          if (rest != '0) begin
            mem_we = 1'b1;
            mem_wa = hit_idx;
            mem_wd = {new_off, rest};
          end
        end
        SM_SHIFT: begin
          mem_we = 1'b1;
          mem_wa = shift_idx;
          mem_wd = rd_data;
        end
        SM_FIN: begin
          if (hit_pad != '0 && room) begin
            mem_we = 1'b1;
            mem_wa = count[IW-1:0];
            mem_wd = {hit_off, hit_pad};
          end
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  // memory read address selection
  always_comb begin
    unique case (state)
      SM_SCAN:  rd_addr = scan_idx + IW'(1);
      SM_UPD:   rd_addr = hit_idx + IW'(1);
      SM_SHIFT: rd_addr = shift_idx + IW'(2);
      default:  rd_addr = '0;
    endcase
  end

  // free list storage
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[rd_addr];
  end

  // sequencer, bookkeeping and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= SM_INIT;
      count      <= CW'(1);
      used_total <= '0;
      pool_bytes <= ffa_pkg::POOL_RESET;
      align_log2 <= ffa_pkg::ALIGN_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        SM_INIT: begin
          state <= SM_IDLE;
        end
        SM_IDLE: begin
          if (accept) begin
            cnt_r <= in_cnt;
            if (action == ffa_pkg::ACT_FREE) begin
              // free: append unmerged and answer at once
              used_total     <= used_sub;
              used_bytes     <= used_sub;
              granted_offset <= '0;
              out_valid      <= 1'b1;
              if (room) begin
                count        <= count + CW'(1);
                status       <= ffa_pkg::ST_OK;
                free_entries <= ent_app;
              end else begin
                status       <= ffa_pkg::ST_LOST;
                free_entries <= ent_now;
              end
            end else if (count == '0) begin
              status         <= ffa_pkg::ST_NOFIT;
              granted_offset <= '0;
              used_bytes     <= used_total;
              free_entries   <= ent_now;
              out_valid      <= 1'b1;
            end else begin
              scan_idx <= '0;
              state    <= SM_SCAN;
            end
          end
        end
        SM_SCAN: begin
          // one entry per cycle, first fit wins
          if (fit) begin
            hit_idx     <= scan_idx;
            hit_off     <= rd_off;
            hit_size    <= rd_size;
            hit_aligned <= aligned_w[A-1:0];
            hit_pad     <= pad_c;
            hit_pc      <= pc_c;
            state       <= SM_UPD;
          end else if (scan_last) begin
            status         <= ffa_pkg::ST_NOFIT;
            granted_offset <= '0;
            used_bytes     <= used_total;
            free_entries   <= ent_now;
            out_valid      <= 1'b1;
            state          <= SM_IDLE;
          end else begin
            scan_idx <= scan_idx + IW'(1);
          end
        end
        SM_UPD: begin
          // shrink in place, or remove and close up
          if (rest != '0) begin
            state <= SM_FIN;
          end else if ((CW'(hit_idx) + CW'(1)) < count) begin
            shift_idx <= hit_idx;
            state     <= SM_SHIFT;
          end else begin
            count <= count - CW'(1);
            state <= SM_FIN;
          end
        end
        SM_SHIFT: begin
          shift_idx <= shift_idx + IW'(1);
          if (shift_last) begin
            count <= count - CW'(1);
            state <= SM_FIN;
          end
        end
        SM_FIN: begin
          // padding entry goes at the end, then answer
          used_total     <= used_add;
          used_bytes     <= used_add;
          granted_offset <= 32'(hit_aligned);
          out_valid      <= 1'b1;
          state          <= SM_IDLE;
          if (hit_pad != '0 && room) begin
            count        <= count + CW'(1);
            status       <= ffa_pkg::ST_OK;
            free_entries <= ent_app;
          end else begin
            status       <= (hit_pad != '0) ? ffa_pkg::ST_LOST : ffa_pkg::ST_OK;
            free_entries <= ent_now;
          end
        end
        default: begin
          state <= SM_IDLE;
        end
      endcase

      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          ffa_pkg::REG_POOL: begin
            pool_bytes <= cfg_data;
            count      <= CW'(1);
          end
          ffa_pkg::REG_ALIGN: begin
            align_log2 <= cfg_data[4:0];
          end
          default: begin
            align_log2 <= align_log2;
          end
        endcase
      end
    end
  end

  // entry count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(FREE_SLOTS))
    else $error("free list count beyond table size");

  // a scan only runs over a non-empty list
  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == SM_SCAN |-> count != '0)
    else $error("scan over empty free list");

  // close-up never moves from past the last entry
  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    state == SM_SHIFT |-> (CW'(shift_idx) + CW'(1)) < count)
    else $error("close-up beyond list end");

  // no result is pending while a request is being worked on
  a_busy_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == SM_SCAN || state == SM_UPD || state == SM_SHIFT || state == SM_FIN)
      |-> !out_valid)
    else $error("result pending while busy");

endmodule

@@ test/tb_first_fit_aligned_allocator.sv @@
// self-checking testbench for the first-fit aligned allocator: directed table, then random traffic
`timescale 1ns / 100ps

module tb_first_fit_aligned_allocator;

  localparam int SLOTS = ffa_pkg::FREE_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 2 * SLOTS + 10;
  localparam int PHASES = 10;
  localparam int PHASE_REQUESTS = 125;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] granted;
    logic [31:0] used;
    logic [6:0]  entries;
  } ffa_result_t;

  typedef enum {ROW_REQUEST, ROW_REGISTER} row_kind_t;

  typedef struct {
    row_kind_t                     kind;
    logic                          act;
    logic [31:0]                   cnt;
    logic [31:0]                   off;
    logic [ffa_pkg::REG_IDX_W-1:0] idx;
    int                            rep;
    bit                            pinned;
    ffa_result_t                   want;
  } stim_row_t;

  typedef struct {
    bit          pinned;
    ffa_result_t want;
  } pinned_result_t;

  typedef struct {
    logic [31:0] off;
    logic [31:0] len;
  } grant_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [ffa_pkg::REG_IDX_W-1:0] cfg_index;
  logic [31:0]                   cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  logic                          action;
  logic [31:0]                   byte_count;
  logic [31:0]                   block_offset;
  logic                          out_valid;
  logic                          out_stall;
  logic [1:0]                    status;
  logic [31:0]                   granted_offset;
  logic [31:0]                   used_bytes;
  logic [6:0]                    free_entries;

  // allocator state as the testbench sees it
  logic [31:0] fl_off [SLOTS];
  logic [31:0] fl_size [SLOTS];
  int          fl_count;
  logic [31:0] used_model;
  logic [31:0] pool_model;
  logic [4:0]  align_model;

  ffa_result_t    expected_results[$];
  pinned_result_t pinned_q[$];
  grant_t         live_grants[$];
  stim_row_t      rows[$];

  int  errors;
  int  cycles;
  int  n_alloc;
  int  n_free;
  int  n_checked;
  int  n_ok;
  int  n_nofit;
  int  n_lost;
  bit  calm;
  bit  long_hold_req;

  first_fit_aligned_allocator dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .byte_count     (byte_count),
    .block_offset   (block_offset),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .granted_offset (granted_offset),
    .used_bytes     (used_bytes),
    .free_entries   (free_entries)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycles);
      $display("[first_fit_aligned_allocator] ERROR");
      $finish;
    end
  end

  // free list back to one whole-pool entry
  function automatic void clear_free_list();
    fl_off[0]  = 32'd0;
    fl_size[0] = pool_model;
    fl_count   = 1;
  endfunction

  // append at the end, false when the table is full
  function automatic bit append_entry(logic [31:0] off, logic [31:0] len);
    if (fl_count >= SLOTS) return 1'b0;
    fl_off[fl_count]  = off;
    fl_size[fl_count] = len;
    fl_count++;
    return 1'b1;
  endfunction

  // first-fit allocate or unmerged free, updating the tracked state
  function automatic ffa_result_t predict_request(logic act, logic [31:0] cnt, logic [31:0] off);
    ffa_result_t r;
    logic [32:0] low_mask;
    logic [32:0] aligned;
    logic [31:0] base;
    logic [31:0] pad;
    logic [31:0] rest;
    bit          found;
    r = '{ffa_pkg::ST_OK, 32'd0, 32'd0, 7'd0};
    found = 1'b0;
    if (act == ffa_pkg::ACT_ALLOC) begin
      low_mask = (33'd1 << align_model) - 33'd1;
      for (int i = 0; i < fl_count && !found; i++) begin
        base = fl_off[i];
        aligned = ({1'b0, base} + low_mask) & ~low_mask;
        // rounded offset past the address range
        if (aligned[32]) continue;
        pad = aligned[31:0] - base;
        if (pad > fl_size[i] || cnt > fl_size[i] - pad) continue;
        found = 1'b1;
        rest = fl_size[i] - pad - cnt;
        if (rest != 32'd0) begin
          fl_off[i]  = aligned[31:0] + cnt;
          fl_size[i] = rest;
        end else begin
          // entry used up, later entries close up
          for (int j = i; j + 1 < fl_count; j++) begin
            fl_off[j]  = fl_off[j + 1];
            fl_size[j] = fl_size[j + 1];
          end
          fl_count--;
        end
        if (pad != 32'd0 && !append_entry(base, pad)) r.status = ffa_pkg::ST_LOST;
        r.granted = aligned[31:0];
        if ({1'b0, used_model} + {1'b0, cnt} > 33'h0_FFFF_FFFF) used_model = 32'hFFFF_FFFF;
        else used_model = used_model + cnt;
        live_grants.insert(live_grants.size(), '{aligned[31:0], cnt});
        if (live_grants.size() > 256) void'(live_grants.pop_front());
      end
      if (!found) r.status = ffa_pkg::ST_NOFIT;
    end else begin
      if (!append_entry(off, cnt)) r.status = ffa_pkg::ST_LOST;
      if (cnt >= used_model) used_model = 32'd0;
      else used_model = used_model - cnt;
    end
    r.used    = used_model;
    r.entries = fl_count[6:0];
    return r;
  endfunction

  function automatic stim_row_t req_row(logic act, logic [31:0] cnt, logic [31:0] off, int rep);
    stim_row_t r;
    r = '{ROW_REQUEST, act, cnt, off, ffa_pkg::REG_POOL, rep, 1'b0, '0};
    return r;
  endfunction

  function automatic stim_row_t pinned_row(logic act, logic [31:0] cnt, logic [31:0] off,
                                           ffa_result_t want);
    stim_row_t r;
    r = '{ROW_REQUEST, act, cnt, off, ffa_pkg::REG_POOL, 1, 1'b1, want};
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [ffa_pkg::REG_IDX_W-1:0] idx, logic [31:0] val);
    stim_row_t r;
    r = '{ROW_REGISTER, ffa_pkg::ACT_ALLOC, val, 32'd0, idx, 0, 1'b0, '0};
    return r;
  endfunction

  // directed table grows at the end
  function automatic void add_row(stim_row_t r);
    rows.insert(rows.size(), r);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // request channel: optional gap, then hold the request until taken
  task automatic send_request(logic act, logic [31:0] cnt, logic [31:0] off, bit pinned,
                              ffa_result_t want);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    pinned_q.insert(pinned_q.size(), '{pinned, want});
    in_valid     <= 1'b1;
    action       <= act;
    byte_count   <= cnt;
    block_offset <= off;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0 || pinned_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // one register write while the block is idle
  task automatic write_reg(logic [ffa_pkg::REG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == ffa_pkg::REG_POOL) begin
      pool_model = val;
      clear_free_list();
      live_grants.delete();
    end else begin
      align_model = val[4:0];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // result channel: random stall bursts, one long hold on request
  initial begin
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  // predict on each taken request, check each taken result
  always @(posedge clk) begin : monitor
    ffa_result_t    pred;
    ffa_result_t    want;
    pinned_result_t tag;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        pred = predict_request(action, byte_count, block_offset);
        tag = pinned_q.pop_front();
        expected_results.insert(expected_results.size(), tag.pinned ? tag.want : pred);
        if (action == ffa_pkg::ACT_ALLOC) n_alloc++;
        else n_free++;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t unexpected result: status %h offset %h used %h entries %0d",
                   $time, status, granted_offset, used_bytes, free_entries);
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          check_field("status", 32'(want.status), 32'(status));
          check_field("granted_offset", want.granted, granted_offset);
          check_field("used_bytes", want.used, used_bytes);
          check_field("free_entries", 32'(want.entries), 32'(free_entries));
          case (want.status)
            ffa_pkg::ST_OK:    n_ok++;
            ffa_pkg::ST_NOFIT: n_nofit++;
            ffa_pkg::ST_LOST:  n_lost++;
            default:  ;
          endcase
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [31:0] cnt;
    logic [31:0] off;
    logic [31:0] span;
    logic        act;
    logic [31:0] pool_val;
    logic [31:0] align_val;
    int          pick;
    int          k;
    grant_t      g;

    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = ffa_pkg::REG_POOL;
    cfg_data     = 32'd0;
    in_valid     = 1'b0;
    action       = ffa_pkg::ACT_ALLOC;
    byte_count   = 32'd0;
    block_offset = 32'd0;
    errors = 0;
    cycles = 0;
    n_alloc = 0;
    n_free = 0;
    n_checked = 0;
    n_ok = 0;
    n_nofit = 0;
    n_lost = 0;
    calm = 1'b0;
    long_hold_req = 1'b0;
    pool_model  = ffa_pkg::POOL_RESET;
    align_model = ffa_pkg::ALIGN_RESET;
    used_model  = 32'd0;
    clear_free_list();

    // directed table: reset defaults, extremes, saturation, wrap, full table
    add_row(pinned_row(ffa_pkg::ACT_ALLOC, 32'd0, 32'd0,
                       '{ffa_pkg::ST_OK, 32'd0, 32'd0, 7'd1}));
    add_row(pinned_row(ffa_pkg::ACT_ALLOC, 32'd100, 32'd0,
                       '{ffa_pkg::ST_OK, 32'd0, 32'd100, 7'd1}));
    add_row(pinned_row(ffa_pkg::ACT_ALLOC, 32'd256, 32'hFFFF_FFFF,
                       '{ffa_pkg::ST_OK, 32'd256, 32'd356, 7'd2}));
    add_row(pinned_row(ffa_pkg::ACT_ALLOC, 32'hFFFF_FFFF, 32'd0,
                       '{ffa_pkg::ST_NOFIT, 32'd0, 32'd356, 7'd2}));
    add_row(pinned_row(ffa_pkg::ACT_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       '{ffa_pkg::ST_OK, 32'd0, 32'd0, 7'd3}));
    add_row(pinned_row(ffa_pkg::ACT_FREE, 32'd0, 32'd0,
                       '{ffa_pkg::ST_OK, 32'd0, 32'd0, 7'd4}));
    add_row(req_row(ffa_pkg::ACT_ALLOC, 32'h00FF_FE00, 32'd0, 1));
    add_row(reg_row(ffa_pkg::REG_ALIGN, 32'd0));
    add_row(req_row(ffa_pkg::ACT_ALLOC, 32'd1, 32'd0, 1));
    add_row(reg_row(ffa_pkg::REG_ALIGN, 32'd16));
    add_row(req_row(ffa_pkg::ACT_ALLOC, 32'd1000, 32'd0, 1));
    add_row(reg_row(ffa_pkg::REG_ALIGN, 32'd31));
    add_row(req_row(ffa_pkg::ACT_ALLOC, 32'd0, 32'd0, 1));
    add_row(reg_row(ffa_pkg::REG_POOL, 32'd1));
    add_row(req_row(ffa_pkg::ACT_ALLOC, 32'd1, 32'd0, 1));
    add_row(req_row(ffa_pkg::ACT_ALLOC, 32'd0, 32'd0, 1));
    add_row(req_row(ffa_pkg::ACT_FREE, 32'd5, 32'h1234_5679, SLOTS + 1));
    add_row(reg_row(ffa_pkg::REG_ALIGN, 32'd2));
    add_row(req_row(ffa_pkg::ACT_ALLOC, 32'd1, 32'd0, 1));
    add_row(reg_row(ffa_pkg::REG_POOL, 32'hFFFF_FFFF));
    add_row(pinned_row(ffa_pkg::ACT_ALLOC, 32'hFFFF_FFFF, 32'd0,
                       '{ffa_pkg::ST_OK, 32'd0, 32'hFFFF_FFFF, 7'd0}));
    add_row(req_row(ffa_pkg::ACT_FREE, 32'h8000_0000, 32'd0, 1));
    add_row(req_row(ffa_pkg::ACT_ALLOC, 32'd3, 32'd0, 1));

    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // walk the directed table
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REGISTER) begin
        wait_drained();
        write_reg(rows[i].idx, rows[i].cnt);
      end else begin
        repeat (rows[i].rep)
          send_request(rows[i].act, rows[i].cnt, rows[i].off, rows[i].pinned, rows[i].want);
      end
    end

    // random phases, each with a fresh pool and alignment
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      calm = (ph == PHASES - 1);
      pick = $urandom_range(0, 5);
      case (pick)
        0: pool_val = 32'hFFFF_FFFF;
        1: pool_val = $urandom_range(1, 64);
        2: pool_val = ffa_pkg::POOL_RESET;
        3: pool_val = $urandom_range(1, 1 << 20);
        default: pool_val = $urandom | 32'd1;
      endcase
      pick = $urandom_range(0, 6);
      case (pick)
        0: align_val = 32'd0;
        1: align_val = 32'd16;
        2: align_val = $urandom_range(17, 31);
        default: align_val = $urandom_range(0, 10);
      endcase
      write_reg(ffa_pkg::REG_POOL, pool_val);
      write_reg(ffa_pkg::REG_ALIGN, align_val);
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        if (ph == 3 && n == 20) long_hold_req = 1'b1;
        if (ph == 6 && n == 60) wait_drained();
        pick = $urandom_range(0, 99);
        off = $urandom;
        if (pick < 80 && pick >= 50 && live_grants.size() != 0) begin
          // give back a block that was actually granted
          k = $urandom_range(0, live_grants.size() - 1);
          g = live_grants[k];
          live_grants.delete(k);
          act = ffa_pkg::ACT_FREE;
          cnt = g.len;
          off = g.off;
        end else if (pick < 80) begin
          // allocate a size scaled to the pool
          span = pool_model >> $urandom_range(1, 8);
          act = ffa_pkg::ACT_ALLOC;
          cnt = $urandom_range(0, span);
        end else if (pick < 90) begin
          act = ffa_pkg::ACT_ALLOC;
          cnt = $urandom;
        end else begin
          act = ffa_pkg::ACT_FREE;
          cnt = $urandom;
        end
        send_request(act, cnt, off, 1'b0, '0);
      end
    end

    // let the last results come back
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d allocate and %0d free requests over %0d pool settings",
             n_alloc, n_free, PHASES + 3);
    $display("checked %0d results: %0d ok, %0d without fit, %0d with a dropped entry",
             n_checked, n_ok, n_nofit, n_lost);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("[first_fit_aligned_allocator] OK");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, expected_results.size());
      $display("[first_fit_aligned_allocator] ERROR");
    end
    $finish;
  end

endmodule
